FILE: sv/mmf_pkg.sv
// Shared types and constants of the moving median filter.
package mmf_pkg;

    // Sample width of x and y, signed Q16.16.
    localparam int SAMPLE_BITS = 32;
    // Width of the half-width register.
    localparam int HW_BITS = 4;
    // Width of the window length and of the ranking counters (2*15+1 = 31).
    localparam int LEN_BITS = 5;
    // Points-seen counter width and its saturation value.
    localparam int SEEN_BITS = 6;
    localparam logic [SEEN_BITS-1:0] SEEN_MAX = 6'd63;
    // Smallest result delay in points.
    localparam logic [HW_BITS-1:0] MIN_DELAY = 4'd2;
    // Half-width after reset.
    localparam logic [HW_BITS-1:0] HALF_WIDTH_RESET = 4'd1;

    // One input item.
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] x_value;
        logic signed [SAMPLE_BITS-1:0] y_value;
        logic                          last_point;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] x_out;
        logic signed [SAMPLE_BITS-1:0] median_out;
        logic                          last_out;
    } t_out_item;

endpackage

FILE: sv/moving_median_filter_edge_shrink.sv
// Moving median filter with shrinking windows at the dataset edges.
//
// Usage: points enter on the input channel (i_in_valid / o_in_stall), one
// point per item, the final point of a dataset marked by last_point. Each
// point comes back on the output channel (o_out_valid / i_out_stall) with x
// unchanged and y replaced by the median of a centered window of 2H+1
// samples, H shrinking near both ends of the dataset. Results trail their
// point by max(H,2) points; the remaining ones are flushed after the last
// point. Datasets of one or two points give no results.
// The half-width H is written on the configuration channel (always ready)
// and is taken up at the first point of the next dataset.
// Throughput: the block takes an item only while idle. Each result goes
// through a setup state, a ranking state that tries the window samples in
// turn as candidates until it finds the median, and an emit state. The rank
// of one candidate is counted by a single shared comparator against every
// window sample, one sample per cycle, from a two-read-port sample ring.
// Reset sets H to 1, empties the dataset and the output register; the rings
// need no clearing. When the receiver stalls, the finished result is held in
// the output register and the sequencer waits before loading the next one.
module moving_median_filter_edge_shrink #(
    parameter int MAX_WINDOW = 21
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  mmf_pkg::t_in_item    i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output mmf_pkg::t_out_item   o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [mmf_pkg::HW_BITS-1:0] i_cfg_data
);

    localparam int RING_LEN = MAX_WINDOW + 1;
    localparam int AW       = $clog2(RING_LEN);
    localparam int SW       = ((AW > mmf_pkg::LEN_BITS) ? AW : mmf_pkg::LEN_BITS) + 1;
    localparam int MAX_HALF = (MAX_WINDOW - 1) / 2;
    localparam int HB       = mmf_pkg::HW_BITS;
    localparam int LB       = mmf_pkg::LEN_BITS;
    localparam int PB       = mmf_pkg::SEEN_BITS;
    localparam int SB       = mmf_pkg::SAMPLE_BITS;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SETUP,
        S_RANK,
        S_EMIT
    } t_state;

    // Modular reduction of a sum that is known to stay below twice the ring length.
    function automatic logic [AW-1:0] f_wrap(input logic [SW-1:0] s);
        logic [SW-1:0] t;
        begin
            t = s - SW'(RING_LEN);
            f_wrap = (s >= SW'(RING_LEN)) ? t[AW-1:0] : s[AW-1:0];
        end
    endfunction

    // Sample rings.
    logic signed [SB-1:0] r_y_ring [RING_LEN];
    logic signed [SB-1:0] r_x_ring [RING_LEN];
    logic signed [SB-1:0] r_qa, r_qb, r_xq;

    // Control and working registers.
    t_state            r_state, n_state;
    logic [HB-1:0]     r_half_width, n_half_width;
    logic [HB-1:0]     r_active_h, n_active_h;
    logic [PB-1:0]     r_points_seen, n_points_seen;
    logic [AW-1:0]     r_head, n_head;
    logic [AW-1:0]     r_newest, n_newest;
    logic [HB-1:0]     r_r, n_r;
    logic [PB-1:0]     r_idx, n_idx;
    logic              r_at_end, n_at_end;
    logic [HB-1:0]     r_h, n_h;
    logic [LB-1:0]     r_len, n_len;
    logic [AW-1:0]     r_pos, n_pos;
    logic [AW-1:0]     r_base, n_base;
    logic [LB-1:0]     r_k, n_k;
    logic [LB-1:0]     r_j, n_j;
    logic [LB-1:0]     r_lt, n_lt;
    logic [LB-1:0]     r_eq, n_eq;
    logic              r_pv, n_pv;
    logic              r_plast, n_plast;
    logic signed [SB-1:0] r_med, n_med;
    logic              r_out_valid, n_out_valid;
    mmf_pkg::t_out_item r_out_data, n_out_data;

    // Combinational helpers.
    logic              in_accept;
    logic [HB-1:0]     act_h;
    logic [HB-1:0]     delay;
    logic [PB-1:0]     idx_half;
    logic [LB-1:0]     r_plus1;
    logic [HB-1:0]     h_sel;
    logic [AW-1:0]     pos_c;
    logic [AW-1:0]     addr_a, addr_b;
    logic [LB:0]       lt_n, eq_n;
    logic              found;
    logic              out_free;

    assign in_accept   = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign out_free    = !r_out_valid || !i_out_stall;

    // Half-width taken up at the first point of a dataset, clamped to the ring.
    always_comb begin
        if (r_points_seen == '0) begin
            if (int'(r_half_width) > MAX_HALF) begin
                act_h = HB'(MAX_HALF);
            end else begin
                act_h = r_half_width;
            end
        end else begin
            act_h = r_active_h;
        end
        delay = (act_h < mmf_pkg::MIN_DELAY) ? mmf_pkg::MIN_DELAY : act_h;
    end

    // Window half-width of the current result, shrunk near both dataset edges.
    always_comb begin
        idx_half = (r_idx - PB'(1)) >> 1;
        r_plus1  = LB'(r_r) + LB'(1);
        h_sel    = r_active_h;
        if (r_idx == '0 || (r_at_end && r_r == '0)) begin
            h_sel = '0;
        end else begin
            if (r_idx < PB'(r_active_h) && idx_half < PB'(h_sel)) begin
                h_sel = idx_half[HB-1:0];
            end
            if (r_at_end && r_plus1 <= LB'(r_active_h) && (r_plus1 >> 1) < LB'(h_sel)) begin
                h_sel = HB'(r_plus1 >> 1);
            end
        end
        pos_c = f_wrap(SW'(r_newest) + SW'(RING_LEN) - SW'(r_r));
    end

    // Ring addresses of the rank candidate and of the sample it is compared with.
    assign addr_a = f_wrap(SW'(r_base) + SW'(r_k));
    assign addr_b = f_wrap(SW'(r_base) + SW'(r_j));

    // Shared comparator: count samples below and equal to the candidate.
    always_comb begin
        lt_n  = (LB + 1)'(r_lt) + (LB + 1)'(r_qb < r_qa);
        eq_n  = (LB + 1)'(r_eq) + (LB + 1)'(r_qb == r_qa);
        found = r_pv && r_plast && (lt_n <= (LB + 1)'(r_h))
                && ((LB + 1)'(r_h) < lt_n + eq_n);
    end

    // Sequencer next-state logic.
    always_comb begin
        n_state       = r_state;
        n_half_width  = r_half_width;
        n_active_h    = r_active_h;
        n_points_seen = r_points_seen;
        n_head        = r_head;
        n_newest      = r_newest;
        n_r           = r_r;
        n_idx         = r_idx;
        n_at_end      = r_at_end;
        n_h           = r_h;
        n_len         = r_len;
        n_pos         = r_pos;
        n_base        = r_base;
        n_k           = r_k;
        n_j           = r_j;
        n_lt          = r_lt;
        n_eq          = r_eq;
        n_pv          = 1'b0;
        n_plast       = 1'b0;
        n_med         = r_med;
        n_out_valid   = r_out_valid;
        n_out_data    = r_out_data;

        // Output register drains whenever the receiver takes the item.
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        if (i_cfg_valid) begin
            n_half_width = i_cfg_data;
        end

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_active_h = act_h;
                    n_newest   = r_head;
                    n_head     = f_wrap(SW'(r_head) + SW'(1));
                    if (i_in_data.last_point) begin
                        n_points_seen = '0;
                        n_at_end      = 1'b1;
                        if (r_points_seen >= PB'(2)) begin
                            if (r_points_seen < PB'(delay)) begin
                                n_r = r_points_seen[HB-1:0];
                            end else begin
                                n_r = delay;
                            end
                            n_idx   = r_points_seen - PB'(n_r);
                            n_state = S_SETUP;
                        end
                    end else begin
                        if (r_points_seen != mmf_pkg::SEEN_MAX) begin
                            n_points_seen = r_points_seen + PB'(1);
                        end
                        n_at_end = 1'b0;
                        if (r_points_seen >= PB'(delay)) begin
                            n_r     = delay;
                            n_idx   = r_points_seen - PB'(delay);
                            n_state = S_SETUP;
                        end
                    end
                end
            end

            S_SETUP: begin
                n_h     = h_sel;
                n_len   = {h_sel, 1'b1};
                n_pos   = pos_c;
                n_base  = f_wrap(SW'(pos_c) + SW'(RING_LEN) - SW'(h_sel));
                n_k     = '0;
                n_j     = '0;
                n_lt    = '0;
                n_eq    = '0;
                n_state = S_RANK;
            end

            S_RANK: begin
                // Issue the next pair of reads.
                n_pv    = 1'b1;
                n_plast = (r_j == r_len - LB'(1));
                if (r_j == r_len - LB'(1)) begin
                    n_j = '0;
                    n_k = r_k + LB'(1);
                end else begin
                    n_j = r_j + LB'(1);
                end
                // Accumulate the compare of the pair read last cycle.
                if (r_pv) begin
                    if (r_plast) begin
                        n_lt = '0;
                        n_eq = '0;
                    end else begin
                        n_lt = lt_n[LB-1:0];
                        n_eq = eq_n[LB-1:0];
                    end
                end
                if (found) begin
                    n_med   = r_qa;
                    n_pv    = 1'b0;
                    n_state = S_EMIT;
                end
            end

            S_EMIT: begin
                if (out_free) begin
                    n_out_valid           = 1'b1;
                    n_out_data.x_out      = r_xq;
                    n_out_data.median_out = r_med;
                    n_out_data.last_out   = r_at_end && (r_r == '0);
                    if (r_at_end && r_r != '0) begin
                        n_r     = r_r - HB'(1);
                        n_idx   = r_idx + PB'(1);
                        n_state = S_SETUP;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_half_width  <= mmf_pkg::HALF_WIDTH_RESET;
            r_active_h    <= mmf_pkg::HALF_WIDTH_RESET;
            r_points_seen <= '0;
            r_head        <= '0;
            r_pv          <= 1'b0;
            r_plast       <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_half_width  <= n_half_width;
            r_active_h    <= n_active_h;
            r_points_seen <= n_points_seen;
            r_head        <= n_head;
            r_pv          <= n_pv;
            r_plast       <= n_plast;
            r_out_valid   <= n_out_valid;
        end
        r_newest   <= n_newest;
        r_r        <= n_r;
        r_idx      <= n_idx;
        r_at_end   <= n_at_end;
        r_h        <= n_h;
        r_len      <= n_len;
        r_pos      <= n_pos;
        r_base     <= n_base;
        r_k        <= n_k;
        r_j        <= n_j;
        r_lt       <= n_lt;
        r_eq       <= n_eq;
        r_med      <= n_med;
        r_out_data <= n_out_data;
    end

    // Sample rings: one write per accepted item, registered reads.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_y_ring[r_head] <= i_in_data.y_value;
            r_x_ring[r_head] <= i_in_data.x_value;
        end
        r_qa <= r_y_ring[addr_a];
        r_qb <= r_y_ring[addr_b];
        r_xq <= r_x_ring[r_pos];
    end

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the moving median filter with shrinking edge windows.

// Predicts the filtered points and checks them against what the block returns.
class median_scoreboard;
    localparam int RING_LEN = 22;
    localparam int MAX_HALF = 10;
    localparam int WIN_MAX = 21;
    localparam int unsigned SEEN_LIMIT = 63;

    logic signed [mmf_pkg::SAMPLE_BITS-1:0] y_ring[RING_LEN];
    logic signed [mmf_pkg::SAMPLE_BITS-1:0] x_ring[RING_LEN];
    int unsigned seen;
    int unsigned head;
    int unsigned cur_half;
    int unsigned half_reg;
    mmf_pkg::t_out_item pending[$];
    int unsigned errors;

    function new();
        for (int k = 0; k < RING_LEN; k++) begin
            y_ring[k] = '0;
            x_ring[k] = '0;
        end
        seen = 0;
        head = 0;
        cur_half = mmf_pkg::HALF_WIDTH_RESET;
        half_reg = mmf_pkg::HALF_WIDTH_RESET;
        errors = 0;
    endfunction

    function void set_half_width(logic [mmf_pkg::HW_BITS-1:0] v);
        half_reg = v;
    endfunction

    function int unsigned ring_pos(int unsigned pos, int unsigned back, int unsigned fwd);
        return (pos + RING_LEN + fwd - back) % RING_LEN;
    endfunction

    // Median of the window around the point r steps behind the newest one.
    function void predict_point(int unsigned newest, int unsigned r, int unsigned idx,
                                bit at_end);
        logic signed [mmf_pkg::SAMPLE_BITS-1:0] win[WIN_MAX];
        logic signed [mmf_pkg::SAMPLE_BITS-1:0] t;
        mmf_pkg::t_out_item res;
        int unsigned pos;
        int unsigned h;
        int a;
        pos = ring_pos(newest, r, 0);
        h = cur_half;
        if (idx == 0 || (at_end && r == 0)) begin
            h = 0;
        end else begin
            // Lead-in and lead-out shrinking; the smaller one wins.
            if (idx < cur_half && (idx - 1) / 2 < h) h = (idx - 1) / 2;
            if (at_end && r + 1 <= cur_half && (r + 1) / 2 < h) h = (r + 1) / 2;
        end
        for (int k = 0; k < 2 * h + 1; k++) win[k] = y_ring[ring_pos(pos, h, k)];
        // Insertion sort on signed samples.
        for (int k = 1; k < 2 * h + 1; k++) begin
            t = win[k];
            a = k;
            while (a > 0 && win[a-1] > t) begin
                win[a] = win[a-1];
                a--;
            end
            win[a] = t;
        end
        res.x_out = x_ring[pos];
        res.median_out = win[h];
        res.last_out = at_end && r == 0;
        pending.push_back(res);
    endfunction

    // Notes one accepted point and queues the results it releases.
    function void note_point(mmf_pkg::t_in_item p);
        int unsigned cur;
        int unsigned j;
        int unsigned d;
        int unsigned cnt;
        if (seen == 0) cur_half = (half_reg > MAX_HALF) ? MAX_HALF : half_reg;
        cur = head;
        y_ring[cur] = p.y_value;
        x_ring[cur] = p.x_value;
        head = (head + 1) % RING_LEN;
        j = seen;
        if (seen < SEEN_LIMIT) seen++;
        d = (cur_half < mmf_pkg::MIN_DELAY) ? mmf_pkg::MIN_DELAY : cur_half;
        if (!p.last_point) begin
            if (j >= d) predict_point(cur, d, j - d, 1'b0);
            return;
        end
        // Last point: flush the trailing points, oldest first.
        seen = 0;
        if (j < 2) return;
        cnt = ((j < d) ? j : d) + 1;
        for (int r = cnt - 1; r >= 0; r--) predict_point(cur, r, j - r, 1'b1);
    endfunction

    // Compares one returned point with the oldest prediction.
    function void check_result(mmf_pkg::t_out_item got);
        mmf_pkg::t_out_item want;
        if (pending.size() == 0) begin
            $error("unexpected result: x_out %h median_out %h last_out %0b",
                   got.x_out, got.median_out, got.last_out);
            errors++;
            return;
        end
        want = pending.pop_front();
        if (got.x_out !== want.x_out) begin
            $error("x_out: expected %h, got %h", want.x_out, got.x_out);
            errors++;
        end
        if (got.median_out !== want.median_out) begin
            $error("median_out: expected %h, got %h", want.median_out, got.median_out);
            errors++;
        end
        if (got.last_out !== want.last_out) begin
            $error("last_out: expected %0b, got %0b", want.last_out, got.last_out);
            errors++;
        end
    endfunction
endclass

module tb;
    localparam int SETTLE_CYCLES = 1000;
    localparam int HOLD_CYCLES = 2000;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_POINTS = 180;
    localparam int CFG_BITS = mmf_pkg::HW_BITS;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_stall;
    mmf_pkg::t_in_item i_in_data;
    logic o_out_valid;
    logic i_out_stall;
    mmf_pkg::t_out_item o_out_data;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic [CFG_BITS-1:0] i_cfg_data;

    median_scoreboard sb;
    int unsigned idle_cycles;
    int unsigned points_sent;
    bit hold_req;
    bit rx_steady;

    moving_median_filter_edge_shrink #(
        .MAX_WINDOW(21)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Gap length: mostly none or short, now and then long.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Random ordinate: full range, a narrow range with ties, or extremes.
    function automatic logic signed [mmf_pkg::SAMPLE_BITS-1:0] pick_y(int mode);
        int r;
        if (mode == 1) return $signed($urandom_range(0, 6)) - 3;
        if (mode == 2) begin
            r = $urandom_range(0, 4);
            case (r)
                0: return 32'sh7fffffff;
                1: return 32'sh80000000;
                2: return 32'sh0;
                3: return -32'sd1;
                default: return $urandom;
            endcase
        end
        return $urandom;
    endfunction

    // Offers one item and waits until it is accepted; called at a falling edge.
    task automatic send_point(mmf_pkg::t_in_item p, bit steady);
        int n;
        n = steady ? 0 : gap_len();
        if (n > 0) begin
            i_in_valid = 1'b0;
            repeat (n) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_data = p;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_point(p);
        points_sent++;
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    task automatic send_xy(logic [mmf_pkg::SAMPLE_BITS-1:0] x,
                           logic [mmf_pkg::SAMPLE_BITS-1:0] y, bit last);
        mmf_pkg::t_in_item p;
        p.x_value = x;
        p.y_value = y;
        p.last_point = last;
        send_point(p, 1'b0);
    endtask

    task automatic send_dataset(int n, int ymode, bit steady);
        mmf_pkg::t_in_item p;
        for (int i = 0; i < n; i++) begin
            p.x_value = $urandom;
            p.y_value = pick_y(ymode);
            p.last_point = (i == n - 1);
            send_point(p, steady);
        end
    endtask

    // Waits until every predicted point has come back and the block has settled.
    task automatic wait_idle();
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_half_width(logic [CFG_BITS-1:0] v);
        i_cfg_valid = 1'b1;
        i_cfg_data = v;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_half_width(v);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Receiver: random stalls, quiet stretches, and one long hold on request.
    initial begin
        int n;
        bit hold_done;
        i_out_stall = 1'b0;
        rx_steady = 1'b0;
        hold_done = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_done) begin
                i_out_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_done = 1'b1;
                i_out_stall = 1'b0;
            end else begin
                if ($urandom_range(0, 49) == 0) rx_steady = !rx_steady;
                n = rx_steady ? 0 : gap_len();
                if (n > 0) begin
                    i_out_stall = 1'b1;
                    repeat (n) @(negedge i_clk);
                    i_out_stall = 1'b0;
                end
            end
        end
    end

    // Result monitor and watchdog on accepted items.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) sb.check_result(o_out_data);
            if ((o_out_valid && !i_out_stall) || (i_in_valid && !o_in_stall) ||
                (i_cfg_valid && o_cfg_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // Main sequence.
    initial begin
        int phase;
        int random_start;
        int len;
        int half_list[7];
        sb = new();
        half_list = '{10, 0, 15, 2, 5, 1, 7};
        points_sent = 0;
        hold_req = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: reset half-width, extreme samples, short datasets.
        send_xy(32'h7fffffff, 32'h7fffffff, 1'b0);
        send_xy(32'h80000000, 32'h80000000, 1'b0);
        send_xy(32'h00000000, 32'h00000000, 1'b1);
        send_xy(32'hffffffff, 32'h12345678, 1'b1);
        send_xy(32'h00010000, 32'hffff0000, 1'b0);
        send_xy(32'h00020000, 32'h00008000, 1'b1);
        send_xy(32'h00000001, 32'h00000005, 1'b0);
        send_xy(32'h00000002, 32'hfffffffd, 1'b0);
        send_xy(32'h00000003, 32'h80000000, 1'b0);
        send_xy(32'h00000004, 32'h7fffffff, 1'b0);
        send_xy(32'h00000005, 32'hffffffff, 1'b1);
        // Half-width above range, dataset shorter than the window.
        wait_idle();
        write_half_width(4'd15);
        send_dataset(12, 0, 1'b0);

        // Random phases, each under its own half-width.
        random_start = points_sent;
        phase = 0;
        while (points_sent - random_start < RANDOM_POINTS) begin
            wait_idle();
            write_half_width(CFG_BITS'((phase < 7) ? half_list[phase]
                                                   : $urandom_range(0, 15)));
            if (phase == 0) begin
                // Long dataset: the point counter saturates.
                send_dataset(70, 0, 1'b0);
                // Receiver holds off while points keep coming.
                hold_req = 1'b1;
                send_dataset(30, 0, 1'b1);
            end
            repeat ($urandom_range(2, 4)) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2)
                                                  : $urandom_range(3, 16);
                send_dataset(len, $urandom_range(0, 2), $urandom_range(0, 3) == 0);
            end
            phase++;
        end

        // Drain and settle.
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
